// File: hw/rtl/wdor_pkg.sv
// Package for the wraparound dimension-order route block: sizes, types and helpers.
package wdor_pkg;

  // Dimensions that the hardware carries, and those in use.
  localparam int MAX_DIMS   = 4;
  localparam int NUM_DIMS   = 4;
  // Coordinate width in use; ring lengths go up to 2**COORD_BITS.
  localparam int COORD_BITS = 6;

  // Fixed field widths of the ports.
  localparam int DEST_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int POS_W      = 6;
  localparam int ID_W       = 24;
  localparam int DIM_W      = 2;

  // Derived widths.
  localparam int LW      = COORD_BITS + 1;
  localparam int DW      = COORD_BITS + 2;
  localparam int CMP_W   = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
  localparam int LEN_MAX = 1 << COORD_BITS;
  localparam logic [LW-1:0] LEN_MAX_L = LW'(LEN_MAX);

  // Cycles for the geometry registers to settle after a register write:
  // lengths, then one stride per dimension after the first, then the
  // products, then the sum.
  localparam int SETTLE   = MAX_DIMS + 2;
  localparam int SETTLE_W = $clog2(SETTLE + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEN_DIM0,
    REG_LEN_DIM1,
    REG_LEN_DIM2,
    REG_LEN_DIM3,
    REG_POS_DIM0,
    REG_POS_DIM1,
    REG_POS_DIM2,
    REG_POS_DIM3
  } cfg_reg_t;

  // Geometry of the node, derived from the registers.
  typedef struct packed {
    logic                               busy;
    logic [MAX_DIMS-1:0][LW-1:0]         len;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0] own;
    logic [MAX_DIMS-1:0][ID_W-1:0]       stride;
    logic [MAX_DIMS-1:0][ID_W-1:0]       wrap;
    logic [ID_W-1:0]                     own_id;
  } geom_t;

  // Effective ring length: zero counts as one, large values saturate.
  function automatic logic [LW-1:0] eff_len_f(input logic [CFG_DATA_W-1:0] raw);
    logic [CMP_W-1:0] r;
    r = CMP_W'(raw);
    if (r == '0) begin
      return LW'(1);
    end else if (r > CMP_W'(LEN_MAX)) begin
      return LEN_MAX_L;
    end else begin
      return LW'(r);
    end
  endfunction

  // Coordinate saturated to one below the ring length.
  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic [CMP_W-1:0] c,
                                                        input logic [LW-1:0] len);
    if (c >= CMP_W'(len)) begin
      return COORD_BITS'(len - LW'(1));
    end else begin
      return COORD_BITS'(c);
    end
  endfunction

endpackage

// File: hw/rtl/wdor_ifs.sv
// Channel interfaces of the wraparound dimension-order route block.
interface wdor_cfg_if import wdor_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface wdor_in_if import wdor_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_coord_0;
  logic [DEST_W-1:0] dest_coord_1;
  logic [DEST_W-1:0] dest_coord_2;
  logic [DEST_W-1:0] dest_coord_3;

  modport source (output valid, dest_coord_0, dest_coord_1, dest_coord_2, dest_coord_3,
                  input ready);
  modport sink   (input valid, dest_coord_0, dest_coord_1, dest_coord_2, dest_coord_3,
                  output ready);
endinterface

interface wdor_out_if import wdor_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             at_destination;
  logic [DIM_W-1:0] out_dim;
  logic             out_plus;
  logic [ID_W-1:0]  next_hop_id;
  logic             virtual_channel;

  modport source (output valid, at_destination, out_dim, out_plus, next_hop_id,
                  virtual_channel, input ready);
  modport sink   (input valid, at_destination, out_dim, out_plus, next_hop_id,
                  virtual_channel, output ready);
endinterface

// File: hw/rtl/wdor_geom.sv
// Configuration registers and the node geometry derived from them.
module wdor_geom import wdor_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wdor_cfg_if.sink   cfg,
  output geom_t      geom
);

  logic [MAX_DIMS-1:0][CFG_DATA_W-1:0] len_raw;
  logic [MAX_DIMS-1:0][POS_W-1:0]      pos_raw;
  logic [SETTLE_W-1:0]                 settle_cnt;

  logic [MAX_DIMS-1:0][LW-1:0]         eff_len;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] own_c;
  logic [MAX_DIMS-1:0][ID_W-1:0]       stride;
  logic [MAX_DIMS-1:0][ID_W-1:0]       wrap;
  logic [MAX_DIMS-1:0][ID_W-1:0]       own_part;
  logic [ID_W-1:0]                     own_id;

  logic [MAX_DIMS-2:0][ID_W+LW-1:0]         stride_prod;
  logic [MAX_DIMS-1:0][ID_W+LW-1:0]         wrap_prod;
  logic [MAX_DIMS-1:0][ID_W+COORD_BITS-1:0] own_prod;
  logic [ID_W-1:0]                          own_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        len_raw[d] <= CFG_DATA_W'(1);
        pos_raw[d] <= '0;
      end
      settle_cnt <= SETTLE_W'(SETTLE);
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index <= REG_LEN_DIM3) begin
        len_raw[cfg.index[DIM_W-1:0]] <= cfg.data;
      end else begin
        pos_raw[cfg.index[DIM_W-1:0]] <= cfg.data[POS_W-1:0];
      end
      settle_cnt <= SETTLE_W'(SETTLE);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - SETTLE_W'(1);
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS - 1; d++) begin
      stride_prod[d] = (ID_W+LW)'(stride[d]) * (ID_W+LW)'(eff_len[d]);
    end
    for (int d = 0; d < MAX_DIMS; d++) begin
      wrap_prod[d] = (ID_W+LW)'(stride[d]) * (ID_W+LW)'(eff_len[d] - LW'(1));
      own_prod[d]  = (ID_W+COORD_BITS)'(stride[d]) * (ID_W+COORD_BITS)'(own_c[d]);
    end
    own_sum = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      own_sum = own_sum + own_part[d];
    end
  end

  // The geometry recomputes every cycle; each product is registered before use.
  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < NUM_DIMS) begin
        eff_len[d] <= eff_len_f(len_raw[d]);
        own_c[d]   <= clamp_coord(CMP_W'(pos_raw[d]), eff_len_f(len_raw[d]));
      end else begin
        eff_len[d] <= LW'(1);
        own_c[d]   <= '0;
      end
      wrap[d]     <= wrap_prod[d][ID_W-1:0];
      own_part[d] <= own_prod[d][ID_W-1:0];
    end
    stride[0] <= ID_W'(1);
    for (int d = 1; d < MAX_DIMS; d++) begin
      stride[d] <= stride_prod[d-1][ID_W-1:0];
    end
    own_id <= own_sum;
  end

  assign geom.busy   = (settle_cnt != '0);
  assign geom.len    = eff_len;
  assign geom.own    = own_c;
  assign geom.stride = stride;
  assign geom.wrap   = wrap;
  assign geom.own_id = own_id;

endmodule

// File: hw/rtl/wraparound_dim_order_route_core.sv
// Top level of the wraparound dimension-order route block.
//
//   channel    | direction | transfer carries
//   -----------+-----------+--------------------------------------------------
//   cfg        | in        | register index and write data
//   route_in   | in        | destination coordinates of one packet header
//   route_out  | out       | local flag, port dimension, direction, next id, VC
//
// Each header is routed by logic between the input channel and the result
// register, from which it leaves on route_out; a new header can be taken every
// cycle while the geometry is settled and the result register is free or being
// drained. After reset and after every register write the geometry (strides,
// own id) resettles, and route_in is not ready until it has settled.
// A stall on route_out holds the result register and stops route_in.
// Reset is synchronous and active high; it restores lengths of one and
// coordinates of zero.
module wraparound_dim_order_route_core import wdor_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wdor_cfg_if.sink    cfg,
  wdor_in_if.sink     route_in,
  wdor_out_if.source  route_out
);

  geom_t geom;

  wdor_geom u_geom (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  logic                                in_accept;
  logic [MAX_DIMS-1:0][DEST_W-1:0]     dst_in;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] dst_c;
  logic [MAX_DIMS-1:0]                 differ;
  logic [MAX_DIMS-1:0]                 dir_plus;
  logic signed [DW-1:0]                diff [MAX_DIMS];
  logic signed [DW-1:0]                half [MAX_DIMS];

  logic             found;
  logic [DIM_W-1:0] sel;
  logic             sel_plus;
  logic             wrap_hit;
  logic             add;
  logic [ID_W-1:0]  mag;
  logic [ID_W-1:0]  hop_id;

  logic             res_local;
  logic [DIM_W-1:0] res_dim;
  logic             res_plus;
  logic [ID_W-1:0]  res_id;
  logic             res_vc;

  // Result register.
  logic             out_valid;
  logic             at_destination;
  logic [DIM_W-1:0] out_dim;
  logic             out_plus;
  logic [ID_W-1:0]  next_hop_id;
  logic             virtual_channel;

  assign dst_in[0] = route_in.dest_coord_0;
  assign dst_in[1] = route_in.dest_coord_1;
  assign dst_in[2] = route_in.dest_coord_2;
  assign dst_in[3] = route_in.dest_coord_3;

  // Unused dimensions have length one and coordinate zero in the geometry,
  // so the clamp forces their destination to zero and they never differ.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      dst_c[d]  = clamp_coord(CMP_W'(dst_in[d]), geom.len[d]);
      differ[d] = (dst_c[d] != geom.own[d]);
      diff[d]   = $signed(DW'(geom.own[d])) - $signed(DW'(dst_c[d]));
      half[d]   = $signed(DW'(geom.len[d] >> 1));
      // Shorter way round; on an even-length tie, minus when own is larger.
      if (diff[d] > half[d]) begin
        dir_plus[d] = 1'b1;
      end else if (diff[d] < -half[d]) begin
        dir_plus[d] = 1'b0;
      end else if (diff[d] > 0) begin
        dir_plus[d] = 1'b0;
      end else begin
        dir_plus[d] = 1'b1;
      end
    end
  end

  // Lowest differing dimension, then one hop along its ring. The next id is the
  // own id moved by one stride, or by (len - 1) strides the other way at a wrap.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (!found && differ[d]) begin
        found = 1'b1;
        sel   = DIM_W'(d);
      end
    end
    sel_plus = dir_plus[sel];
    if (sel_plus) begin
      wrap_hit = ((LW'(geom.own[sel]) + LW'(1)) == geom.len[sel]);
    end else begin
      wrap_hit = (geom.own[sel] == '0);
    end
    add    = sel_plus ^ wrap_hit;
    mag    = wrap_hit ? geom.wrap[sel] : geom.stride[sel];
    hop_id = add ? (geom.own_id + mag) : (geom.own_id - mag);

    if (found) begin
      res_local = 1'b0;
      res_dim   = sel;
      res_plus  = sel_plus;
      res_id    = hop_id;
      res_vc    = (geom.own_id > hop_id);
    end else begin
      res_local = 1'b1;
      res_dim   = '0;
      res_plus  = 1'b0;
      res_id    = geom.own_id;
      res_vc    = 1'b0;
    end
  end

  assign route_in.ready = !geom.busy && (!out_valid || route_out.ready);
  assign in_accept      = route_in.valid && route_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (route_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      at_destination  <= res_local;
      out_dim         <= res_dim;
      out_plus        <= res_plus;
      next_hop_id     <= res_id;
      virtual_channel <= res_vc;
    end
  end

  assign route_out.valid           = out_valid;
  assign route_out.at_destination  = at_destination;
  assign route_out.out_dim         = out_dim;
  assign route_out.out_plus        = out_plus;
  assign route_out.next_hop_id     = next_hop_id;
  assign route_out.virtual_channel = virtual_channel;

endmodule
